// ===== src/pwbb_pkg.sv =====
// Shared types, codes and the microcode table of the posted-write bus bridge.
`default_nettype none

package pwbb_pkg;

  // Field widths.
  localparam int CMD_W    = 4;
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int PORT_W   = 16;
  localparam int KIND_W   = 2;
  localparam int SEL_W    = 2;
  localparam int CFG_AW   = 3;
  localparam int STEP_W   = 5;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_WR8   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_WR16  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_WR32  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_RD8   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_RD16  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RD32  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_WRST  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_RDST  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 4'd8;
  localparam logic [CMD_W-1:0] CMD_PDATA = 4'd9;

  // Result kinds and port registers.
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STROBE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESULT = 2'd2;

  localparam logic [SEL_W-1:0] SEL_DATA = 2'd0;
  localparam logic [SEL_W-1:0] SEL_ALO  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_AHI  = 2'd2;
  localparam logic [SEL_W-1:0] SEL_STAT = 2'd3;

  // Access sizes and address-high codes.
  localparam logic [1:0] SZ_BYTE = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_LONG = 2'd3;

  localparam logic [1:0] CODE_WBYTE = 2'd1;
  localparam logic [1:0] CODE_WORD  = 2'd2;
  localparam logic [1:0] CODE_RBYTE = 2'd3;

  // Pending read kinds.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_BYTE = 2'd1;
  localparam logic [1:0] PEND_WORD = 2'd2;
  localparam logic [1:0] PEND_LONG = 2'd3;

  localparam logic [ADDR_W-1:0] TOP_BYTE_MASK = 32'hFF00_0000;

  // Configuration register index.
  localparam logic REG_QUEUE_ENABLE = 1'b0;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    EM_NONE,
    EM_DATA,
    EM_ALO,
    EM_AHI,
    EM_STROBE,
    EM_STAT_W,
    EM_STROBE_S,
    EM_RESULT
  } emit_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_PUSH,
    A_POP,
    A_POP_PUSH,
    A_LD_IN,
    A_SPLIT,
    A_LD_RD,
    A_SET_PEND,
    A_LD_RD2,
    A_CLR_PEND
  } act_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_END,
    C_GOTO,
    C_IF_BYPASS,
    C_IF_FULL,
    C_IF_EMPTY,
    C_IF_STATUS,
    C_IF_CONT,
    C_END_IF_EMPTY,
    C_END_IF_NOPEND,
    C_WRET
  } cond_t;

  typedef struct packed {
    emit_t em;
    act_t  act;
    cond_t cond;
    step_t target;
  } ucw_t;

  // Program steps.
  localparam step_t ST_W0    = 5'd0;
  localparam step_t ST_W1    = 5'd1;
  localparam step_t ST_W2    = 5'd2;
  localparam step_t ST_WFULL = 5'd3;
  localparam step_t ST_WBY   = 5'd4;
  localparam step_t ST_WS0   = 5'd5;
  localparam step_t ST_WS1   = 5'd6;
  localparam step_t ST_WS2   = 5'd7;
  localparam step_t ST_WS3   = 5'd8;
  localparam step_t ST_D0    = 5'd9;
  localparam step_t ST_D1    = 5'd10;
  localparam step_t ST_DCHK  = 5'd11;
  localparam step_t ST_DPOP  = 5'd12;
  localparam step_t ST_RSEL  = 5'd13;
  localparam step_t ST_RA0   = 5'd14;
  localparam step_t ST_RA1   = 5'd15;
  localparam step_t ST_RA2   = 5'd16;
  localparam step_t ST_RSTAT = 5'd17;
  localparam step_t ST_ST0   = 5'd18;
  localparam step_t ST_PD0   = 5'd19;
  localparam step_t ST_PD1   = 5'd20;
  localparam step_t ST_PD2   = 5'd21;
  localparam step_t ST_PDC   = 5'd22;
  localparam step_t ST_IGN   = 5'd23;

  // Control store: one word per step.
  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    w = '{EM_NONE, A_NONE, C_END, ST_IGN};
    unique case (step)
      ST_W0:    w = '{EM_NONE,     A_NONE,     C_IF_BYPASS,     ST_WBY};
      ST_W1:    w = '{EM_NONE,     A_NONE,     C_IF_FULL,       ST_WFULL};
      ST_W2:    w = '{EM_NONE,     A_PUSH,     C_END,           ST_IGN};
      ST_WFULL: w = '{EM_NONE,     A_POP_PUSH, C_GOTO,          ST_WS0};
      ST_WBY:   w = '{EM_NONE,     A_LD_IN,    C_GOTO,          ST_WS0};
      ST_WS0:   w = '{EM_DATA,     A_NONE,     C_NEXT,          ST_IGN};
      ST_WS1:   w = '{EM_ALO,      A_NONE,     C_NEXT,          ST_IGN};
      ST_WS2:   w = '{EM_AHI,      A_NONE,     C_WRET,          ST_DCHK};
      ST_WS3:   w = '{EM_NONE,     A_SPLIT,    C_GOTO,          ST_WS0};
      ST_D0:    w = '{EM_NONE,     A_NONE,     C_END_IF_EMPTY,  ST_IGN};
      ST_D1:    w = '{EM_NONE,     A_POP,      C_GOTO,          ST_WS0};
      ST_DCHK:  w = '{EM_NONE,     A_NONE,     C_IF_EMPTY,      ST_RSEL};
      ST_DPOP:  w = '{EM_NONE,     A_POP,      C_GOTO,          ST_WS0};
      ST_RSEL:  w = '{EM_NONE,     A_LD_RD,    C_IF_STATUS,     ST_RSTAT};
      ST_RA0:   w = '{EM_ALO,      A_NONE,     C_NEXT,          ST_IGN};
      ST_RA1:   w = '{EM_AHI,      A_NONE,     C_NEXT,          ST_IGN};
      ST_RA2:   w = '{EM_STROBE,   A_SET_PEND, C_END,           ST_IGN};
      ST_RSTAT: w = '{EM_STROBE_S, A_SET_PEND, C_END,           ST_IGN};
      ST_ST0:   w = '{EM_STAT_W,   A_NONE,     C_END,           ST_IGN};
      ST_PD0:   w = '{EM_NONE,     A_NONE,     C_END_IF_NOPEND, ST_IGN};
      ST_PD1:   w = '{EM_NONE,     A_NONE,     C_IF_CONT,       ST_PDC};
      ST_PD2:   w = '{EM_RESULT,   A_CLR_PEND, C_END,           ST_IGN};
      ST_PDC:   w = '{EM_NONE,     A_LD_RD2,   C_GOTO,          ST_RA0};
      default:  w = '{EM_NONE,     A_NONE,     C_END,           ST_IGN};
    endcase
    return w;
  endfunction

  // Dispatch table: first step of each command's program.
  function automatic step_t entry_of(input logic [CMD_W-1:0] cmd);
    step_t s;
    unique case (cmd)
      CMD_WR8, CMD_WR16, CMD_WR32:           s = ST_W0;
      CMD_RD8, CMD_RD16, CMD_RD32, CMD_RDST: s = ST_DCHK;
      CMD_WRST:                              s = ST_ST0;
      CMD_DRAIN:                             s = ST_D0;
      CMD_PDATA:                             s = ST_PD0;
      default:                               s = ST_IGN;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/pwbb_if.sv =====
// Valid/ready channel interfaces for bridge commands and port transactions.
`default_nettype none

interface pwbb_in_if import pwbb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic [PORT_W-1:0] port_data;

  modport source (output valid, cmd, address, write_data, port_data, input ready);
  modport sink   (input valid, cmd, address, write_data, port_data, output ready);
endinterface

interface pwbb_out_if import pwbb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SEL_W-1:0]  reg_sel;
  logic [PORT_W-1:0] port_value;
  logic [DATA_W-1:0] read_value;
  logic              last;

  modport source (output valid, kind, reg_sel, port_value, read_value, last, input ready);
  modport sink   (input valid, kind, reg_sel, port_value, read_value, last, output ready);
endinterface

`default_nettype wire

// ===== src/posted_write_bus_bridge.sv =====
// Posted-write bus bridge: microcoded sequencer that turns accesses into port words.
// Commands are taken one at a time: a new command is accepted only while the sequencer is idle,
// and the sequencer then runs one microcode step per cycle unless an emitting step waits on a
// stalled out_ch. Each emitted word is held in the output register until out_ch takes it.
// Reset (rst_n low, synchronous): FIFO empty, no read pending, queueing enabled.
`default_nettype none

module posted_write_bus_bridge import pwbb_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire                clk,
  input  wire                rst_n,
  pwbb_in_if.sink            in_ch,
  pwbb_out_if.source         out_ch,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [CFG_AW-1:0]  paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

  // Sequencer and latched command.
  logic              busy_r;
  step_t             step_r;
  logic              drain_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] wd_r;
  logic [PORT_W-1:0] pd_r;

  // Current write or read job.
  logic [ADDR_W-1:0] job_addr_r;
  logic [DATA_W-1:0] job_val_r;
  logic [1:0]        job_size_r;
  logic [1:0]        job_code_r;

  // Posted-write FIFO.
  logic [ADDR_W-1:0] q_addr_m [QUEUE_DEPTH];
  logic [DATA_W-1:0] q_val_m  [QUEUE_DEPTH];
  logic [1:0]        q_size_m [QUEUE_DEPTH];
  logic [SLOT_W-1:0] hd_slot_r, hd_slot_nxt, tl_slot_r, tl_slot_nxt;
  logic              hd_wrap_r, hd_wrap_nxt, tl_wrap_r, tl_wrap_nxt;

  // Read tracking.
  logic [1:0]        pend_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic [PORT_W-1:0] upper_r;
  logic              phase_r;
  logic              qen_r;

  // Output register.
  logic              out_v_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SEL_W-1:0]  out_sel_r;
  logic [PORT_W-1:0] out_pv_r;
  logic [DATA_W-1:0] out_rv_r;
  logic              out_last_r;

  ucw_t              cw;
  step_t             step_nxt;
  logic              finish;
  logic              adv;
  logic              emits;
  logic              accept;
  logic              q_empty, q_full, bypass, is_status, no_pend, cont;
  logic              do_push, do_pop;
  logic [DATA_W-1:0] in_val;
  logic [1:0]        in_size;
  logic [1:0]        in_code;
  logic [1:0]        rd_kind;
  logic [PORT_W-1:0] data_word;
  logic [KIND_W-1:0] em_kind;
  logic [SEL_W-1:0]  em_sel;
  logic [PORT_W-1:0] em_pv;
  logic [DATA_W-1:0] em_rv;
  logic              cfg_wr;

  assign cw        = ucode_rom(step_r);
  assign q_empty   = (hd_slot_r == tl_slot_r) && (hd_wrap_r == tl_wrap_r);
  assign q_full    = (hd_slot_r == tl_slot_r) && (hd_wrap_r != tl_wrap_r);
  assign bypass    = !(qen_r && ((addr_r & TOP_BYTE_MASK) == '0));
  assign is_status = (cmd_r == CMD_RDST);
  assign no_pend   = (pend_r == PEND_NONE);
  assign cont      = (pend_r == PEND_LONG) && !phase_r;
  assign emits     = (cw.em != EM_NONE);
  assign adv       = busy_r && (!emits || !out_v_r || out_ch.ready);
  assign accept    = in_ch.valid && rst_n && !busy_r;
  assign do_push   = adv && ((cw.act == A_PUSH) || (cw.act == A_POP_PUSH));
  assign do_pop    = adv && ((cw.act == A_POP) || (cw.act == A_POP_PUSH));

  // Write value and size as posted or sent.
  always_comb begin
    unique case (cmd_r)
      CMD_WR8:  in_val = {24'd0, wd_r[7:0]};
      CMD_WR16: in_val = {16'd0, wd_r[15:0]};
      default:  in_val = wd_r;
    endcase
    in_size = cmd_r[1:0] + 2'd1;
    in_code = (in_size == SZ_BYTE) ? CODE_WBYTE : CODE_WORD;
    rd_kind = cmd_r[1:0] - 2'd2;
  end

  // Sequencer next step.
  always_comb begin
    finish   = 1'b0;
    step_nxt = step_r + 5'd1;
    unique case (cw.cond)
      C_NEXT:          ;
      C_END:           finish = 1'b1;
      C_GOTO:          step_nxt = cw.target;
      C_IF_BYPASS:     if (bypass) step_nxt = cw.target;
      C_IF_FULL:       if (q_full) step_nxt = cw.target;
      C_IF_EMPTY:      if (q_empty) step_nxt = cw.target;
      C_IF_STATUS:     if (is_status) step_nxt = cw.target;
      C_IF_CONT:       if (cont) step_nxt = cw.target;
      C_END_IF_EMPTY:  finish = q_empty;
      C_END_IF_NOPEND: finish = no_pend;
      C_WRET: begin
        // long first half splits; a drain loop returns to its check
        if (job_size_r != SZ_LONG) begin
          if (drain_r) begin
            step_nxt = cw.target;
          end else begin
            finish = 1'b1;
          end
        end
      end
      default:         finish = 1'b1;
    endcase
  end

  // Emitted word.
  always_comb begin
    unique case (job_size_r)
      SZ_BYTE: data_word = {job_addr_r[0] ? 8'd0 : job_val_r[7:0], job_val_r[7:0]};
      SZ_LONG: data_word = job_val_r[31:16];
      default: data_word = job_val_r[15:0];
    endcase
    em_kind = KIND_WRITE;
    em_sel  = SEL_DATA;
    em_pv   = '0;
    em_rv   = '0;
    unique case (cw.em)
      EM_NONE:     ;
      EM_DATA:     em_pv = data_word;
      EM_ALO: begin
        em_sel = SEL_ALO;
        em_pv  = job_addr_r[15:0];
      end
      EM_AHI: begin
        em_sel = SEL_AHI;
        em_pv  = job_addr_r[31:16] | {6'd0, job_code_r, 8'd0};
      end
      EM_STROBE:   em_kind = KIND_STROBE;
      EM_STAT_W: begin
        em_sel = SEL_STAT;
        em_pv  = wd_r[15:0];
      end
      EM_STROBE_S: begin
        em_kind = KIND_STROBE;
        em_sel  = SEL_STAT;
      end
      EM_RESULT: begin
        em_kind = KIND_RESULT;
        unique case (pend_r)
          PEND_BYTE: em_rv = {24'd0, pend_addr_r[0] ? pd_r[7:0] : pd_r[15:8]};
          PEND_LONG: em_rv = {upper_r, pd_r};
          default:   em_rv = {16'd0, pd_r};
        endcase
      end
      default:     ;
    endcase
  end

  // FIFO pointers count slots with a wrap bit.
  always_comb begin
    hd_slot_nxt = hd_slot_r;
    hd_wrap_nxt = hd_wrap_r;
    tl_slot_nxt = tl_slot_r;
    tl_wrap_nxt = tl_wrap_r;
    if (do_push) begin
      if (hd_slot_r == LAST_SLOT) begin
        hd_slot_nxt = '0;
        hd_wrap_nxt = !hd_wrap_r;
      end else begin
        hd_slot_nxt = hd_slot_r + SLOT_W'(1);
      end
    end
    if (do_pop) begin
      if (tl_slot_r == LAST_SLOT) begin
        tl_slot_nxt = '0;
        tl_wrap_nxt = !tl_wrap_r;
      end else begin
        tl_slot_nxt = tl_slot_r + SLOT_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_IGN;
      drain_r     <= 1'b0;
      hd_slot_r   <= '0;
      hd_wrap_r   <= 1'b0;
      tl_slot_r   <= '0;
      tl_wrap_r   <= 1'b0;
      pend_r      <= PEND_NONE;
      pend_addr_r <= '0;
      upper_r     <= '0;
      phase_r     <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      hd_slot_r <= hd_slot_nxt;
      hd_wrap_r <= hd_wrap_nxt;
      tl_slot_r <= tl_slot_nxt;
      tl_wrap_r <= tl_wrap_nxt;
      if (accept) begin
        busy_r  <= 1'b1;
        step_r  <= entry_of(in_ch.cmd);
        drain_r <= (in_ch.cmd == CMD_RD8) || (in_ch.cmd == CMD_RD16) ||
                   (in_ch.cmd == CMD_RD32) || (in_ch.cmd == CMD_RDST);
      end else if (adv) begin
        if (finish) begin
          busy_r <= 1'b0;
        end
        step_r <= step_nxt;
      end
      if (adv) begin
        unique case (cw.act)
          A_SET_PEND: begin
            // the second half of a long read keeps its pending state
            if (cmd_r != CMD_PDATA) begin
              pend_r      <= is_status ? PEND_WORD : rd_kind;
              pend_addr_r <= is_status ? '0 : addr_r;
              phase_r     <= 1'b0;
            end
          end
          A_LD_RD2: begin
            upper_r <= pd_r;
            phase_r <= 1'b1;
          end
          A_CLR_PEND: begin
            pend_r  <= PEND_NONE;
            phase_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (out_v_r && out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (adv && emits) begin
        out_v_r <= 1'b1;
      end
    end
  end

  // Payload, job registers and FIFO storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_ch.cmd;
      addr_r <= in_ch.address;
      wd_r   <= in_ch.write_data;
      pd_r   <= in_ch.port_data;
    end
    if (do_push) begin
      q_addr_m[hd_slot_r] <= addr_r;
      q_val_m[hd_slot_r]  <= in_val;
      q_size_m[hd_slot_r] <= in_size;
    end
    if (do_pop) begin
      // read before the same-edge push; a full FIFO pops and pushes one slot
      job_addr_r <= q_addr_m[tl_slot_r];
      job_val_r  <= q_val_m[tl_slot_r];
      job_size_r <= q_size_m[tl_slot_r];
      job_code_r <= (q_size_m[tl_slot_r] == SZ_BYTE) ? CODE_WBYTE : CODE_WORD;
    end else if (adv) begin
      unique case (cw.act)
        A_LD_IN: begin
          job_addr_r <= addr_r;
          job_val_r  <= in_val;
          job_size_r <= in_size;
          job_code_r <= in_code;
        end
        A_SPLIT: begin
          job_size_r <= SZ_WORD;
          job_addr_r <= job_addr_r + 32'd2;
        end
        A_LD_RD: begin
          job_addr_r <= addr_r;
          job_code_r <= (cmd_r == CMD_RD8) ? CODE_RBYTE : CODE_WORD;
        end
        A_LD_RD2: begin
          job_addr_r <= pend_addr_r + 32'd2;
          job_code_r <= CODE_WORD;
        end
        default: ;
      endcase
    end
    if (adv && emits) begin
      out_kind_r <= em_kind;
      out_sel_r  <= em_sel;
      out_pv_r   <= em_pv;
      out_rv_r   <= em_rv;
      out_last_r <= finish;
    end
  end

  // Configuration register.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_QUEUE_ENABLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qen_r <= 1'b1;
    end else if (cfg_wr) begin
      qen_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_QUEUE_ENABLE) ? {31'd0, qen_r} : 32'd0;
  assign pready = 1'b1;

  assign in_ch.ready       = rst_n && !busy_r;
  assign out_ch.valid      = out_v_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.reg_sel    = out_sel_r;
  assign out_ch.port_value = out_pv_r;
  assign out_ch.read_value = out_rv_r;
  assign out_ch.last       = out_last_r;

  // The final word of a program is flagged and frees the sequencer.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emits && finish) |=> (!busy_r && out_v_r && out_last_r))
    else $error("final word not flagged or sequencer still busy");

  // A read strobe always leaves a read pending.
  a_strobe_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cw.act == A_SET_PEND) |=> (pend_r != PEND_NONE))
    else $error("read strobe sent without a pending read");

  // Never push to a full FIFO without a pop, never pop an empty one.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cw.act == A_PUSH) |-> !q_full)
    else $error("post into full FIFO");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> !q_empty)
    else $error("pop from empty FIFO");

endmodule

`default_nettype wire
